/* src/oaqa_pkg.sv */
// Occupancy/aging arbiter: shared types and constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package oaqa_pkg;

  localparam int NUM_INPUTS = 5;
  localparam int OCC_W      = 5;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 2;

  typedef logic [OCC_W-1:0] occ_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_THRESHOLD = 2'd0,
    REG_MAIN_CAPACITY  = 2'd1
  } cfg_reg_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic active;
    idx_t idx;
    logic nonempty;
  } scan_t;

  typedef struct packed {
    logic valid;
    idx_t queue;
  } grant_t;

endpackage

/* src/occupancy_aging_queue_arbiter_core.sv */
// Occupancy/aging arbiter top level: config registers, cell chain, result buffer.
// Depends on oaqa_pkg, oaqa_cell and oaqa_outbuf.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_stall) carries the occupancy of five input
//  queues and of the main queue. Each transfer runs one priority scan through
//  a chain of five cells, each holding its queue's age counter; the chain
//  settles within the transfer cycle and the age counters update on it.
//  Output channel (out_valid/out_stall) carries grant_valid and grant_queue,
//  one result per input transfer, in order.
//  The result is registered in the result buffer and presented from its head.
//  Throughput: one transfer per cycle while in_stall is low; the cell chain is
//  combinational. A two-entry result buffer lets input transfers continue
//  while the receiver stalls; in_stall rises only when both entries are held.
//  Configuration: cfg_we with cfg_index 0 (full_threshold) or 1
//  (main_capacity); other indices are ignored. Write only while idle.
//  Reset (rst, synchronous): age counters clear, both registers load
//  QUEUE_DEPTH, the result buffer empties.
module occupancy_aging_queue_arbiter_core import oaqa_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  occ_t                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  occ_t                 occupancy_a,
  input  occ_t                 occupancy_b,
  input  occ_t                 occupancy_c,
  input  occ_t                 occupancy_d,
  input  occ_t                 occupancy_e,
  input  occ_t                 main_occupancy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 grant_valid,
  output idx_t                 grant_queue
);

  localparam occ_t RESET_LIMIT = occ_t'(QUEUE_DEPTH);

  occ_t   full_threshold;
  occ_t   main_capacity;
  occ_t   occ [NUM_INPUTS];
  scan_t  scan [NUM_INPUTS+1];
  logic   accept;
  grant_t result;
  grant_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_threshold <= RESET_LIMIT;
      main_capacity  <= RESET_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_THRESHOLD: full_threshold <= cfg_data;
        REG_MAIN_CAPACITY:  main_capacity  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  assign occ[0] = occupancy_a;
  assign occ[1] = occupancy_b;
  assign occ[2] = occupancy_c;
  assign occ[3] = occupancy_d;
  assign occ[4] = occupancy_e;

  assign scan[0] = '{active: 1'b1, idx: '0, nonempty: 1'b0};

  for (genvar i = 0; i < NUM_INPUTS; i++) begin : g_cell
    oaqa_cell #(.CELL_IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (accept),
      .occ      (occ[i]),
      .threshold(full_threshold),
      .scan_in  (scan[i]),
      .scan_out (scan[i+1])
    );
  end

  always_comb begin
    result.valid = !scan[NUM_INPUTS].active && scan[NUM_INPUTS].nonempty &&
                   (main_occupancy < main_capacity);
    result.queue = result.valid ? scan[NUM_INPUTS].idx : '0;
  end

  oaqa_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(result),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign grant_valid = out_data.valid;
  assign grant_queue = out_data.queue;

  a_stall_has_data: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_grant_index: assert property (@(posedge clk) disable iff (rst)
    accept && result.valid |-> result.queue < idx_t'(NUM_INPUTS))
    else $error("grant index out of range");

  a_grant_room: assert property (@(posedge clk) disable iff (rst)
    accept && result.valid |-> main_occupancy < main_capacity)
    else $error("grant while main queue full");

endmodule

/* src/oaqa_cell.sv */
// One queue cell: age counter and its step of the priority scan.
// Depends on oaqa_pkg.
`timescale 1ns / 1ps
module oaqa_cell import oaqa_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  occ_t  occ,
  input  occ_t  threshold,
  input  scan_t scan_in,
  output scan_t scan_out
);

  occ_t age;
  occ_t age_next;
  occ_t age_inc;
  logic partial;
  logic aged_out;
  logic win;

  always_comb begin
    age_inc  = age + occ_t'(1);
    partial  = (occ < threshold) && (occ != '0);
    aged_out = partial && ((age >= threshold) || (age_inc >= threshold));
    win      = scan_in.active && ((occ == threshold) || aged_out);
    age_next = age;
    if (scan_in.active && (occ != threshold) && partial) begin
      age_next = aged_out ? '0 : age_inc;
    end
    scan_out = scan_in;
    if (win) begin
      scan_out.active   = 1'b0;
      scan_out.idx      = idx_t'(CELL_IDX);
      scan_out.nonempty = (occ != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else if (en) begin
      age <= age_next;
    end
  end

  a_win_clears: assert property (@(posedge clk) disable iff (rst)
    en && win && (occ != threshold) |=> age == '0)
    else $error("age not cleared after aged win");

endmodule

/* src/oaqa_outbuf.sv */
// Two-entry result buffer decoupling the scan from the output stall.
// Depends on oaqa_pkg.
`timescale 1ns / 1ps
module oaqa_outbuf import oaqa_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  grant_t push_data,
  output logic   full,
  output logic   out_valid,
  input  logic   out_stall,
  output grant_t out_data
);

  grant_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign pop       = (count != 2'd0) && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("buffer count out of range");

endmodule
